// ----- rtl/core/cba_pkg.sv -----
// ----------------------------------------------------------------------------
// cba_pkg
// shared constants, state type and table entry layout of the block allocator
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int TABLE_BLOCKS = 64;
  localparam int IDX_W        = $clog2(TABLE_BLOCKS);
  localparam int CNT_W        = $clog2(TABLE_BLOCKS + 1);
  localparam int REQ_W        = 7;
  localparam int CFG_W        = 7;
  localparam int START_W      = 6;
  localparam int LINK_W       = 6;
  localparam int LIM_W        = (CNT_W > REQ_W) ? CNT_W : REQ_W;
  localparam int ENTRY_W      = LINK_W + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic              busy;
  } entry_t;

endpackage

// ----- rtl/core/cba_req_if.sv -----
// ----------------------------------------------------------------------------
// cba_req_if
// request channel: number of contiguous blocks wanted
// ----------------------------------------------------------------------------
interface cba_req_if import cba_pkg::*;;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] request_blocks;

  modport source (output valid, output request_blocks, input ready);
  modport sink   (input valid, input request_blocks, output ready);
endinterface

// ----- rtl/core/cba_res_if.sv -----
// ----------------------------------------------------------------------------
// cba_res_if
// result channel: grant flag and first block of the run
// ----------------------------------------------------------------------------
interface cba_res_if import cba_pkg::*;;
  logic               valid;
  logic               ready;
  logic               granted;
  logic [START_W-1:0] start_block;

  modport source (output valid, output granted, output start_block, input ready);
  modport sink   (input valid, input granted, input start_block, output ready);
endinterface

// ----- rtl/core/contiguous_block_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// first-fit allocator of contiguous runs over a table of busy bits and links
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        word
//  -------  ---  ---------------  -----------------------------------------
//  req      in   valid / ready    request_blocks
//  res      out  valid / ready    granted, start_block
//  cfg      in   cfg_we_i only    cfg_wdata_i -> blocks_in_use, no read-back
//
//  a request that must scan the whole table and then mark a run of n blocks
//  is taken in idle, scans every usable entry, marks the n blocks from the
//  last back to the first and hands the result over from the response state;
//  the table ram's single read per cycle sets the scan pace
//  a refused zero-length or oversize request skips the scan and the marking
//  after reset a clearing pass zeroes all TABLE_BLOCKS (64) table entries;
//  no request is taken meanwhile, configuration writes still are
//  a request is taken while an earlier result still waits in the output
//  register; a stalled output only holds the finished result in ST_RESP
//
module contiguous_block_allocator import cba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  cba_req_if.sink          req,
  cba_res_if.source        res,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  // control state
  state_e            state_q, state_d;
  logic [CFG_W-1:0]  blocks_in_use_q;
  logic              chk_vld_q, chk_vld_d;
  logic              out_vld_q, out_vld_d;

  // datapath registers
  logic [IDX_W-1:0]  clr_idx_q, clr_idx_d;
  logic [CNT_W-1:0]  scan_addr_q, scan_addr_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]  want_q, want_d;
  logic [CNT_W-1:0]  limit_q, limit_d;
  logic [IDX_W-1:0]  start_q, start_d;
  logic [IDX_W-1:0]  last_q, last_d;
  logic [IDX_W-1:0]  mark_idx_q, mark_idx_d;
  logic [LINK_W-1:0] old_link_q, old_link_d;
  logic              res_granted_q, res_granted_d;
  logic [IDX_W-1:0]  res_start_q, res_start_d;
  logic              out_granted_q, out_granted_d;
  logic [START_W-1:0] out_start_q, out_start_d;

  // table ram port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;

  // decode of the incoming request against the usable limit
  logic [LIM_W-1:0]  cfg_ext;
  logic [LIM_W-1:0]  lim_ext;
  logic [LIM_W-1:0]  want_ext;
  logic [CNT_W-1:0]  limit_c;
  logic              req_fire;
  logic              req_refuse;

  // scan step results
  logic              issue;
  logic              blk_free;
  logic              found;
  logic              scan_end;
  logic              resp_go;

  cba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // usable limit is the register saturated to the table size
  always_comb begin
    cfg_ext  = LIM_W'(blocks_in_use_q);
    lim_ext  = (cfg_ext > LIM_W'(TABLE_BLOCKS)) ? LIM_W'(TABLE_BLOCKS) : cfg_ext;
    limit_c  = CNT_W'(lim_ext);
    want_ext = LIM_W'(req.request_blocks);
  end

  assign req.ready  = (state_q == ST_IDLE);
  assign req_fire   = req.valid && req.ready;
  // a zero-length request or one longer than the limit is refused at once
  assign req_refuse = (want_ext == '0) || (want_ext > lim_ext);

  // scan: one read issued per cycle, data checked in the next cycle
  assign issue    = (state_q == ST_SCAN) && (scan_addr_q < limit_q);
  assign blk_free = !ram_rdata.busy;
  assign found    = (state_q == ST_SCAN) && chk_vld_q && blk_free
                    && ((run_q + CNT_W'(1)) == want_q);
  assign scan_end = (state_q == ST_SCAN) && chk_vld_q && !found
                    && (CNT_W'(chk_idx_q) == (limit_q - CNT_W'(1)));
  assign resp_go  = (state_q == ST_RESP) && (!out_vld_q || res.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == IDX_W'(TABLE_BLOCKS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_fire) state_d = req_refuse ? ST_RESP : ST_SCAN;
      end
      ST_SCAN: begin
        if (found) begin
          state_d = ST_MARK;
        end else if (scan_end) begin
          state_d = ST_RESP;
        end
      end
      ST_MARK: begin
        if (mark_idx_q == start_q) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (resp_go) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    clr_idx_d     = clr_idx_q;
    scan_addr_d   = scan_addr_q;
    chk_vld_d     = 1'b0;
    chk_idx_d     = chk_idx_q;
    run_d         = run_q;
    want_d        = want_q;
    limit_d       = limit_q;
    start_d       = start_q;
    last_d        = last_q;
    mark_idx_d    = mark_idx_q;
    old_link_d    = old_link_q;
    res_granted_d = res_granted_q;
    res_start_d   = res_start_q;
    out_vld_d     = out_vld_q && !res.ready;
    out_granted_d = out_granted_q;
    out_start_d   = out_start_q;

    ram_we        = 1'b0;
    ram_waddr     = clr_idx_q;
    ram_wdata     = '0;
    ram_raddr     = scan_addr_q[IDX_W-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        // zero one entry per cycle
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = '0;
        clr_idx_d = clr_idx_q + IDX_W'(1);
      end
      ST_IDLE: begin
        if (req_fire) begin
          want_d        = CNT_W'(want_ext);
          limit_d       = limit_c;
          scan_addr_d   = '0;
          run_d         = '0;
          res_granted_d = 1'b0;
          res_start_d   = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          chk_vld_d   = 1'b1;
          chk_idx_d   = scan_addr_q[IDX_W-1:0];
          scan_addr_d = scan_addr_q + CNT_W'(1);
        end
        if (chk_vld_q) begin
          if (blk_free) begin
            run_d = run_q + CNT_W'(1);
            if (run_q == '0) start_d = chk_idx_q;
          end else begin
            run_d = '0;
          end
        end
        if (found) begin
          // the run ends here; keep its old link, marking walks back to start
          last_d     = chk_idx_q;
          mark_idx_d = chk_idx_q;
          old_link_d = ram_rdata.link;
          if (run_q == '0) start_d = chk_idx_q;
        end
      end
      ST_MARK: begin
        ram_we         = 1'b1;
        ram_waddr      = mark_idx_q;
        ram_wdata.busy = 1'b1;
        ram_wdata.link = (mark_idx_q == last_q) ? old_link_q
                         : LINK_W'(CNT_W'(mark_idx_q) + CNT_W'(1));
        mark_idx_d     = mark_idx_q - IDX_W'(1);
        if (mark_idx_q == start_q) begin
          res_granted_d = 1'b1;
          res_start_d   = start_q;
        end
      end
      ST_RESP: begin
        if (resp_go) begin
          out_vld_d     = 1'b1;
          out_granted_d = res_granted_q;
          out_start_d   = START_W'(res_start_q);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      blocks_in_use_q <= CFG_RESET;
      chk_vld_q       <= 1'b0;
      out_vld_q       <= 1'b0;
      clr_idx_q       <= '0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
      clr_idx_q <= clr_idx_d;
      if (cfg_we_i) blocks_in_use_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_addr_q   <= scan_addr_d;
    chk_idx_q     <= chk_idx_d;
    run_q         <= run_d;
    want_q        <= want_d;
    limit_q       <= limit_d;
    start_q       <= start_d;
    last_q        <= last_d;
    mark_idx_q    <= mark_idx_d;
    old_link_q    <= old_link_d;
    res_granted_q <= res_granted_d;
    res_start_q   <= res_start_d;
    out_granted_q <= out_granted_d;
    out_start_q   <= out_start_d;
  end

  assign res.valid       = out_vld_q;
  assign res.granted     = out_granted_q;
  assign res.start_block = out_start_q;

endmodule

// ----- rtl/core/cba_ram.sv -----
// ----------------------------------------------------------------------------
// cba_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- dv/tb_contiguous_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator
// self-checking bench for the first-fit allocator: a short directed plan
// walks the limit register through zero, one, saturation and the full table,
// then randomised phases raise the limit step by step so that runs are
// carved out of fresh space and of holes left behind; every result word is
// checked against the row's own word or a local first-fit model of the table
// ----------------------------------------------------------------------------
module tb_contiguous_block_allocator;
  import cba_pkg::*;

  // expected result word: grant flag and first block of the run
  typedef struct packed {
    logic               granted;
    logic [START_W-1:0] start_block;
  } grant_t;

  // directed plan: either a limit write or an allocation request
  typedef enum logic {
    ROW_LIMIT,
    ROW_ALLOC
  } row_kind_e;

  // typed = 1 means the expected word is spelt out in the row itself
  typedef struct packed {
    row_kind_e          kind;
    logic [REQ_W-1:0]   value;
    logic               typed;
    logic               granted;
    logic [START_W-1:0] start_block;
  } plan_row_t;

  // receiver behaviour, picked at random for each span
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT_STALL,
    RX_HEAVY_STALL,
    RX_BLOCKED
  } rx_mode_e;

  localparam int PLAN_ROWS    = 20;
  localparam int RANDOM_WORDS = 1735;
  // worst request is a full scan plus marking plus hand-over, with margin
  localparam int SETTLE_CYCLES = 2 * TABLE_BLOCKS + 16;
  localparam int REPORT_LIMIT  = 10;

  // the blocks below the limit are filled as follows: limit zero refuses
  // everything, limit one admits a single block, the saturated limit hands
  // out blocks one to four, then limit eight lets a run end exactly on the
  // last usable block
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{ROW_LIMIT, 7'd0,   1'b0, 1'b0, 6'd0},
    '{ROW_ALLOC, 7'd1,   1'b1, 1'b0, 6'd0},  // nothing usable
    '{ROW_ALLOC, 7'd64,  1'b1, 1'b0, 6'd0},
    '{ROW_ALLOC, 7'd0,   1'b1, 1'b0, 6'd0},  // zero-length request
    '{ROW_LIMIT, 7'd1,   1'b0, 1'b0, 6'd0},
    '{ROW_ALLOC, 7'd2,   1'b1, 1'b0, 6'd0},  // larger than the limit
    '{ROW_ALLOC, 7'd1,   1'b1, 1'b1, 6'd0},  // the single usable block
    '{ROW_ALLOC, 7'd1,   1'b1, 1'b0, 6'd0},  // now full
    '{ROW_LIMIT, 7'd127, 1'b0, 1'b0, 6'd0},  // saturates to the table size
    '{ROW_ALLOC, 7'd127, 1'b1, 1'b0, 6'd0},  // every request bit set
    '{ROW_ALLOC, 7'd65,  1'b1, 1'b0, 6'd0},
    '{ROW_ALLOC, 7'd0,   1'b1, 1'b0, 6'd0},
    '{ROW_ALLOC, 7'd3,   1'b0, 1'b0, 6'd0},
    '{ROW_ALLOC, 7'd1,   1'b0, 1'b0, 6'd0},
    '{ROW_LIMIT, 7'd8,   1'b0, 1'b0, 6'd0},
    '{ROW_ALLOC, 7'd4,   1'b0, 1'b0, 6'd0},  // full scan, no hole big enough
    '{ROW_ALLOC, 7'd3,   1'b0, 1'b0, 6'd0},  // last start position
    '{ROW_ALLOC, 7'd1,   1'b0, 1'b0, 6'd0},
    '{ROW_LIMIT, 7'd64,  1'b0, 1'b0, 6'd0},
    '{ROW_ALLOC, 7'd2,   1'b0, 1'b0, 6'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  cba_req_if req_ch ();
  cba_res_if res_ch ();

  contiguous_block_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .res        (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // local copy of the allocation table and the limit register
  logic              block_busy [TABLE_BLOCKS];
  logic [LINK_W-1:0] block_link [TABLE_BLOCKS];
  logic [CFG_W-1:0]  limit_reg;

  // grants still owed by the block, oldest first
  grant_t pending_grants [$];

  int fault_count = 0;
  int burst_left  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_fault(input string what, input int want, input int got);
    if (fault_count < REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    fault_count++;
  endtask

  // first fit: lowest start whose whole run is free and below the limit;
  // every block of the run goes busy, all but the last link to the next one
  function automatic grant_t allocate_first_fit(input logic [REQ_W-1:0] want);
    grant_t outcome;
    int     usable;
    int     span;
    int     s;
    int     k;
    bit     fits;
    outcome = '0;
    span    = int'(want);
    usable  = (int'(limit_reg) > TABLE_BLOCKS) ? TABLE_BLOCKS : int'(limit_reg);
    if (span == 0 || span > usable)
      return outcome;
    for (s = 0; s + span <= usable; s++) begin
      fits = 1'b1;
      for (k = s; k < s + span; k++)
        if (block_busy[k]) fits = 1'b0;
      if (fits) begin
        for (k = s; k < s + span - 1; k++) begin
          block_busy[k] = 1'b1;
          block_link[k] = LINK_W'(k + 1);
        end
        block_busy[s + span - 1] = 1'b1;
        outcome.granted     = 1'b1;
        outcome.start_block = START_W'(s);
        return outcome;
      end
    end
    return outcome;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance.
  // the sender works in bursts, with a random gap before each new burst
  task automatic send_word(input logic [REQ_W-1:0] n, input logic typed,
                           input grant_t typed_word);
    grant_t predicted;
    int     gap;
    if (burst_left == 0) begin
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16));
      if (gap > 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      // now and then a long burst with no idling at all
      burst_left = (($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12));
    end
    burst_left--;
    req_ch.valid          = 1'b1;
    req_ch.request_blocks = n;
    do @(posedge clk_i); while (!req_ch.ready);
    // word taken at this edge: advance the model and queue what comes back
    predicted = allocate_first_fit(n);
    pending_grants.push_back(typed ? typed_word : predicted);
    @(negedge clk_i);
  endtask

  // waits until the block has nothing left to say, then lets any work in
  // flight finish before the next register write or the end of the run
  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i  = 1'b0;
    limit_reg = v;
  endtask

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    grant_t oldest;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_grants.size() == 0) begin
        report_fault("unexpected word", 0, 1);
      end else begin
        oldest = pending_grants.pop_front();
        if (res_ch.granted !== oldest.granted)
          report_fault("granted", int'(oldest.granted), int'(res_ch.granted));
        if (res_ch.start_block !== oldest.start_block)
          report_fault("start_block", int'(oldest.start_block),
                       int'(res_ch.start_block));
      end
    end
  end

  // receiver: ready changes at the falling edge, pattern switches every span
  initial begin
    rx_mode_e mode;
    int       span;
    int       k;
    res_ch.ready = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 120);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          RX_OPEN:        res_ch.ready = 1'b1;
          RX_LIGHT_STALL: res_ch.ready = ($urandom_range(0, 3) != 0);
          RX_HEAVY_STALL: res_ch.ready = ($urandom_range(0, 3) == 0);
          default:        res_ch.ready = ((k % 40) >= 30);  // long holds
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [REQ_W-1:0] n;
    int               words_sent;
    int               phase_len;
    int               roll;
    int               grow_limit;
    int               r;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    req_ch.valid          = 1'b0;
    req_ch.request_blocks = '0;
    limit_reg             = CFG_RESET;
    for (r = 0; r < TABLE_BLOCKS; r++) begin
      block_busy[r] = 1'b0;
      block_link[r] = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed plan; requests simply wait out the clearing pass after reset
    for (r = 0; r < PLAN_ROWS; r++) begin
      if (DIRECTED_PLAN[r].kind == ROW_LIMIT)
        write_limit(DIRECTED_PLAN[r].value);
      else
        send_word(DIRECTED_PLAN[r].value, DIRECTED_PLAN[r].typed,
                  '{granted: DIRECTED_PLAN[r].granted,
                    start_block: DIRECTED_PLAN[r].start_block});
    end

    // random phases: first the limit creeps up a few blocks at a time so
    // that fresh space keeps appearing and small holes get reused, then
    // the limit jumps around, zero and saturation among the values
    words_sent = 0;
    grow_limit = 12;
    while (words_sent < RANDOM_WORDS) begin
      if (grow_limit <= TABLE_BLOCKS) begin
        write_limit(CFG_W'(grow_limit));
        grow_limit += $urandom_range(1, 4);
      end else begin
        roll = $urandom_range(0, 9);
        if (roll == 0)      write_limit('0);
        else if (roll == 1) write_limit('1);
        else if (roll == 2) write_limit(CFG_W'(TABLE_BLOCKS));
        else                write_limit(CFG_W'($urandom_range(1, 127)));
      end
      phase_len = $urandom_range(6, 30);
      repeat (phase_len) begin
        // mostly short runs so the table fills slowly, some long ones,
        // some zero-length and some beyond any limit
        roll = $urandom_range(0, 99);
        if (roll < 60)      n = REQ_W'($urandom_range(1, 3));
        else if (roll < 75) n = REQ_W'($urandom_range(4, 16));
        else if (roll < 83) n = REQ_W'($urandom_range(17, 64));
        else if (roll < 90) n = '0;
        else                n = REQ_W'($urandom_range(65, 127));
        send_word(n, 1'b0, '0);
        words_sent++;
      end
    end

    wait_idle();
    fault_count += pending_grants.size();
    if (fault_count == 0)
      $display("contiguous_block_allocator test passed");
    else
      $display("contiguous_block_allocator test failed");
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("contiguous_block_allocator test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/cba_pkg.sv
rtl/core/cba_req_if.sv
rtl/core/cba_res_if.sv
rtl/core/cba_ram.sv
rtl/core/contiguous_block_allocator.sv
dv/tb_contiguous_block_allocator.sv
